FILE: design/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types, codes and helpers for the window stack hit-test and drag block
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int MAX_WINDOWS_DEF = 16;

    localparam int COORD_W    = 16;
    localparam int BTN_W      = 8;
    localparam int SLOT_OUT_W = 4;
    localparam int STATUS_W   = 2;

    // packed stream widths, whole bytes
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;

    localparam logic ACTION_CREATE = 1'b0;
    localparam logic ACTION_MOUSE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_CREATED = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_MOUSE   = 2'd2
    } status_t;

    // one window rectangle as held in the rectangle memory
    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] wide;
        logic [COORD_W-1:0] tall;
    } rect_t;

    // half-open containment, edges summed in 17 bits so they never wrap
    function automatic logic point_inside(rect_t r, logic [COORD_W-1:0] x,
                                          logic [COORD_W-1:0] y);
        logic [COORD_W:0] right;
        logic [COORD_W:0] bottom;
        right  = {1'b0, r.left} + {1'b0, r.wide};
        bottom = {1'b0, r.top} + {1'b0, r.tall};
        return (x >= r.left) && ({1'b0, x} < right) &&
               (y >= r.top) && ({1'b0, y} < bottom);
    endfunction

endpackage

FILE: design/wsd_ram.sv
// ----------------------------------------------------------------------------
// wsd_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module wsd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                        wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/window_stack_hit_test_drag.sv
// ----------------------------------------------------------------------------
// window_stack_hit_test_drag
// window rectangle table with stacking order, pointer hit test and drag
// ----------------------------------------------------------------------------
// one word in gives one word out. create, drag-move and release words go from
// accept straight to the output state. a fresh press scans the stacking memory
// top to bottom through a three-step read pipeline (stacking read, rectangle
// read, test), and a hit below the top then shifts the stacking order up one
// entry per cycle through the single write port and writes the window on top.
// one word is worked on at a time; a new word is taken as soon as the previous
// result sits in the output register.
// the rectangles live in one memory, the bottom-to-top order in another;
// both hold nothing useful until written and get no clearing pass.
module window_stack_hit_test_drag #(
    parameter int MAX_WINDOWS = wsd_pkg::MAX_WINDOWS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // pos_x, pos_y, rect_width, rect_height, buttons
    input  logic [wsd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // action
    input  logic                           s_axis_tuser,
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // window_slot, hit, dragging, drag_slot, drag_new_x, drag_new_y, zero pad
    output logic [wsd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [wsd_pkg::STATUS_W-1:0]   m_axis_tuser
);

    localparam int SLOT_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOWS + 1);
    localparam int WIDE_W = (CNT_W > wsd_pkg::SLOT_OUT_W) ? CNT_W : wsd_pkg::SLOT_OUT_W;
    localparam int CW     = wsd_pkg::COORD_W;
    localparam int RECT_W = $bits(wsd_pkg::rect_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_TOP,
        ST_OUT
    } state_t;

    state_t state_reg;

    // table bookkeeping
    logic [CNT_W-1:0]  count_reg;
    logic              prev_pressed_reg;
    logic              drag_on_reg;
    logic [SLOT_W-1:0] drag_idx_reg;
    logic [CW-1:0]     grab_x_reg;
    logic [CW-1:0]     grab_y_reg;
    // copy of the dragged window, so a move is a single full-word write
    logic [CW-1:0]     drag_x_reg;
    logic [CW-1:0]     drag_y_reg;
    logic [CW-1:0]     drag_w_reg;
    logic [CW-1:0]     drag_h_reg;
    // pointer of the word under work
    logic [CW-1:0]     pt_x_reg;
    logic [CW-1:0]     pt_y_reg;

    // scan pipeline: issue -> stack read (a) -> rect read (b) -> test
    logic [SLOT_W-1:0] iss_idx_reg;
    logic              iss_more_reg;
    logic              a_valid_reg;
    logic [SLOT_W-1:0] a_idx_reg;
    logic              b_valid_reg;
    logic [SLOT_W-1:0] b_idx_reg;
    logic [SLOT_W-1:0] b_slot_reg;
    // stacking position being overwritten while raising
    logic [SLOT_W-1:0] shift_idx_reg;

    // pending result
    wsd_pkg::status_t  res_status_reg;
    logic [wsd_pkg::SLOT_OUT_W-1:0] res_slot_reg;
    logic              res_hit_reg;

    logic                           m_tvalid_reg;
    logic [wsd_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic [wsd_pkg::STATUS_W-1:0]   m_tuser_reg;

    // input word fields
    logic [CW-1:0]              in_x;
    logic [CW-1:0]              in_y;
    logic [CW-1:0]              in_w;
    logic [CW-1:0]              in_h;
    logic [wsd_pkg::BTN_W-1:0]  in_btn;
    logic                       in_pressed;
    logic                       in_accept;

    assign in_x       = s_axis_tdata[CW-1:0];
    assign in_y       = s_axis_tdata[2*CW-1:CW];
    assign in_w       = s_axis_tdata[3*CW-1:2*CW];
    assign in_h       = s_axis_tdata[4*CW-1:3*CW];
    assign in_btn     = s_axis_tdata[4*CW+wsd_pkg::BTN_W-1:4*CW];
    assign in_pressed = |in_btn;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // derived values
    logic              table_full;
    logic [SLOT_W-1:0] new_slot;
    logic [SLOT_W-1:0] last_pos;
    logic [CW-1:0]     move_x;
    logic [CW-1:0]     move_y;
    logic [CNT_W:0]    shift_ahead;

    assign table_full  = (count_reg >= CNT_W'(MAX_WINDOWS));
    assign new_slot    = count_reg[SLOT_W-1:0];
    assign last_pos    = SLOT_W'(count_reg - CNT_W'(1));
    assign move_x      = in_x - grab_x_reg;
    assign move_y      = in_y - grab_y_reg;
    assign shift_ahead = (CNT_W + 1)'(shift_idx_reg) + (CNT_W + 1)'(2);

    // slot numbers widened then cut to the 4-bit result fields
    logic [WIDE_W-1:0] cnt_ext;
    logic [WIDE_W-1:0] hit_ext;
    logic [WIDE_W-1:0] drag_ext;

    assign cnt_ext  = WIDE_W'(count_reg);
    assign hit_ext  = WIDE_W'(b_slot_reg);
    assign drag_ext = WIDE_W'(drag_idx_reg);

    // memories
    logic              rect_we;
    logic [SLOT_W-1:0] rect_waddr;
    wsd_pkg::rect_t    rect_wdata;
    logic              rect_re;
    logic [SLOT_W-1:0] rect_raddr;
    wsd_pkg::rect_t    rect_rd;

    logic              stack_we;
    logic [SLOT_W-1:0] stack_waddr;
    logic [SLOT_W-1:0] stack_wdata;
    logic              stack_re;
    logic [SLOT_W-1:0] stack_raddr;
    logic [SLOT_W-1:0] stack_rd;

    wsd_ram #(
        .DATA_W (RECT_W),
        .DEPTH  (MAX_WINDOWS)
    ) u_rect_ram (
        .clk   (clk),
        .we    (rect_we),
        .waddr (rect_waddr),
        .wdata (rect_wdata),
        .re    (rect_re),
        .raddr (rect_raddr),
        .rdata (rect_rd)
    );

    wsd_ram #(
        .DATA_W (SLOT_W),
        .DEPTH  (MAX_WINDOWS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (stack_re),
        .raddr (stack_raddr),
        .rdata (stack_rd)
    );

    // hit at the test stage of the scan
    logic scan_hit;

    assign scan_hit = (state_reg == ST_SCAN) && b_valid_reg &&
                      wsd_pkg::point_inside(rect_rd, pt_x_reg, pt_y_reg);

    // memory port control
    always_comb
    begin
        rect_we     = 1'b0;
        rect_waddr  = new_slot;
        rect_wdata  = '{left: in_x, top: in_y, wide: in_w, tall: in_h};
        rect_re     = 1'b0;
        rect_raddr  = stack_rd;
        stack_we    = 1'b0;
        stack_waddr = new_slot;
        stack_wdata = new_slot;
        stack_re    = 1'b0;
        stack_raddr = iss_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser == wsd_pkg::ACTION_CREATE)
                    begin
                        // new window lands in the next free slot, on top
                        rect_we  = !table_full;
                        stack_we = !table_full;
                    end
                    else if (in_pressed && prev_pressed_reg && drag_on_reg)
                    begin
                        rect_we    = 1'b1;
                        rect_waddr = drag_idx_reg;
                        rect_wdata = '{left: move_x, top: move_y,
                                       wide: drag_w_reg, tall: drag_h_reg};
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    // prefetch the entry above the hit for the raise
                    stack_re    = 1'b1;
                    stack_raddr = b_idx_reg + SLOT_W'(1);
                end
                else
                begin
                    rect_re  = a_valid_reg;
                    stack_re = iss_more_reg;
                end
            end
            ST_SHIFT:
            begin
                stack_we    = 1'b1;
                stack_waddr = shift_idx_reg;
                stack_wdata = stack_rd;
                stack_re    = (shift_ahead < (CNT_W + 1)'(count_reg));
                stack_raddr = shift_ahead[SLOT_W-1:0];
            end
            ST_TOP:
            begin
                stack_we    = 1'b1;
                stack_waddr = last_pos;
                stack_wdata = b_slot_reg;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer, bookkeeping and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            prev_pressed_reg <= 1'b0;
            drag_on_reg      <= 1'b0;
            drag_idx_reg     <= '0;
            grab_x_reg       <= '0;
            grab_y_reg       <= '0;
            iss_more_reg     <= 1'b0;
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            // taken word leaves, unless a new one is loaded in its place
            if (m_tvalid_reg && m_axis_tready && (state_reg != ST_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        pt_x_reg    <= in_x;
                        pt_y_reg    <= in_y;
                        res_hit_reg <= 1'b0;
                        if (s_axis_tuser == wsd_pkg::ACTION_CREATE)
                        begin
                            state_reg <= ST_OUT;
                            if (table_full)
                            begin
                                res_status_reg <= wsd_pkg::STATUS_FULL;
                                res_slot_reg   <= '0;
                            end
                            else
                            begin
                                res_status_reg <= wsd_pkg::STATUS_CREATED;
                                res_slot_reg   <= cnt_ext[wsd_pkg::SLOT_OUT_W-1:0];
                                count_reg      <= count_reg + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            res_status_reg   <= wsd_pkg::STATUS_MOUSE;
                            res_slot_reg     <= '0;
                            prev_pressed_reg <= in_pressed;
                            if (in_pressed && !prev_pressed_reg)
                            begin
                                // fresh press: scan from the top of the stack
                                if (count_reg != '0)
                                begin
                                    iss_idx_reg  <= last_pos;
                                    iss_more_reg <= 1'b1;
                                    a_valid_reg  <= 1'b0;
                                    b_valid_reg  <= 1'b0;
                                    state_reg    <= ST_SCAN;
                                end
                                else
                                begin
                                    state_reg <= ST_OUT;
                                end
                            end
                            else
                            begin
                                state_reg <= ST_OUT;
                                if (in_pressed)
                                begin
                                    if (drag_on_reg)
                                    begin
                                        drag_x_reg <= move_x;
                                        drag_y_reg <= move_y;
                                    end
                                end
                                else
                                begin
                                    drag_on_reg <= 1'b0;
                                end
                            end
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (scan_hit)
                    begin
                        // raise and grab; first drag position is the window itself
                        grab_x_reg    <= pt_x_reg - rect_rd.left;
                        grab_y_reg    <= pt_y_reg - rect_rd.top;
                        drag_on_reg   <= 1'b1;
                        drag_idx_reg  <= b_slot_reg;
                        drag_x_reg    <= rect_rd.left;
                        drag_y_reg    <= rect_rd.top;
                        drag_w_reg    <= rect_rd.wide;
                        drag_h_reg    <= rect_rd.tall;
                        res_slot_reg  <= hit_ext[wsd_pkg::SLOT_OUT_W-1:0];
                        res_hit_reg   <= 1'b1;
                        shift_idx_reg <= b_idx_reg;
                        iss_more_reg  <= 1'b0;
                        a_valid_reg   <= 1'b0;
                        b_valid_reg   <= 1'b0;
                        state_reg     <= (b_idx_reg == last_pos) ? ST_OUT : ST_SHIFT;
                    end
                    else if (b_valid_reg && (b_idx_reg == '0))
                    begin
                        // bottom reached, press on empty space
                        iss_more_reg <= 1'b0;
                        a_valid_reg  <= 1'b0;
                        b_valid_reg  <= 1'b0;
                        state_reg    <= ST_OUT;
                    end
                    else
                    begin
                        b_valid_reg  <= a_valid_reg;
                        b_idx_reg    <= a_idx_reg;
                        b_slot_reg   <= stack_rd;
                        a_valid_reg  <= iss_more_reg;
                        a_idx_reg    <= iss_idx_reg;
                        iss_idx_reg  <= iss_idx_reg - SLOT_W'(1);
                        iss_more_reg <= iss_more_reg && (iss_idx_reg != '0);
                    end
                end
                ST_SHIFT:
                begin
                    if (shift_ahead < (CNT_W + 1)'(count_reg))
                    begin
                        shift_idx_reg <= shift_idx_reg + SLOT_W'(1);
                    end
                    else
                    begin
                        state_reg <= ST_TOP;
                    end
                end
                ST_TOP:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_axis_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_status_reg;
                        m_tdata_reg  <= {6'd0,
                                         drag_on_reg ? drag_y_reg : 16'd0,
                                         drag_on_reg ? drag_x_reg : 16'd0,
                                         drag_on_reg ?
                                             drag_ext[wsd_pkg::SLOT_OUT_W-1:0] : 4'd0,
                                         drag_on_reg,
                                         res_hit_reg,
                                         res_slot_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // the window count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_WINDOWS))
        else $error("window count beyond table size");

    // a drag only ever refers to a created window and a held button
    assert property (@(posedge clk) disable iff (!rst_n)
        drag_on_reg |-> (CNT_W'(drag_idx_reg) < count_reg) && prev_pressed_reg)
        else $error("drag state inconsistent");

    // the scan test stage only looks at occupied stacking positions
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && b_valid_reg) |-> (CNT_W'(b_idx_reg) < count_reg))
        else $error("scan beyond stack");

    // raising never writes past the top of the stack
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (CNT_W'(shift_idx_reg) + CNT_W'(1) < count_reg))
        else $error("raise shift out of range");
`endif

endmodule
